// ===== design/mtp_pkg.sv =====
package mtp_pkg;

  // Widths fixed by the event and result formats.
  localparam int unsigned KindW   = 5;
  localparam int unsigned CodeW   = 10;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned CountW  = 5;
  localparam int unsigned NumFields = 9;

  // Event types.
  localparam logic [KindW-1:0] EV_SYN = 5'd0;
  localparam logic [KindW-1:0] EV_ABS = 5'd3;

  // Sync codes.
  localparam logic [CodeW-1:0] SYNC_FRAME_END   = 10'h000;
  localparam logic [CodeW-1:0] SYNC_CONTACT_END = 10'h002;

  // Absolute axis codes.
  localparam logic [CodeW-1:0] ABS_TOUCH_MAJOR = 10'h030;
  localparam logic [CodeW-1:0] ABS_TOUCH_MINOR = 10'h031;
  localparam logic [CodeW-1:0] ABS_WIDTH_MAJOR = 10'h032;
  localparam logic [CodeW-1:0] ABS_WIDTH_MINOR = 10'h033;
  localparam logic [CodeW-1:0] ABS_ORIENTATION = 10'h034;
  localparam logic [CodeW-1:0] ABS_POSITION_X  = 10'h035;
  localparam logic [CodeW-1:0] ABS_POSITION_Y  = 10'h036;
  localparam logic [CodeW-1:0] ABS_TRACKING_ID = 10'h039;
  localparam logic [CodeW-1:0] ABS_PRESSURE    = 10'h03a;

  // Position of each contact field inside a slot row.
  typedef enum logic [3:0] {
    FLD_POSITION_X,
    FLD_POSITION_Y,
    FLD_TOUCH_MAJOR,
    FLD_TOUCH_MINOR,
    FLD_WIDTH_MAJOR,
    FLD_WIDTH_MINOR,
    FLD_ORIENTATION,
    FLD_PRESSURE,
    FLD_TRACKING_ID
  } field_e;

  // Commands passed from the front end to the back end.
  typedef enum logic {
    OP_WRITE,
    OP_FLUSH
  } op_e;

  typedef struct packed {
    op_e                op;
    field_e             field;
    logic [ValueW-1:0]  value;
  } cmd_t;

  // One contact slot: all fields side by side.
  typedef logic [NumFields-1:0][ValueW-1:0] row_t;

  // Back end sequencer.
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EMIT
  } bk_state_e;

endpackage

// ===== design/mtp_cmd_fifo.sv =====
module mtp_cmd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FillW = $clog2(Depth + 1);

  logic [Width-1:0] entry_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             do_push, do_pop;

  assign empty_o    = (fill_q == '0);
  assign full_o     = (fill_q == FillW'(Depth));
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  // Pointer and fill bookkeeping; pointers wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      fill_d = FillW'(fill_q + 1'b1);
    end else if (do_pop && !do_push) begin
      fill_d = FillW'(fill_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/mtp_front.sv =====
module mtp_front #(
  parameter int unsigned MaxContacts = 16,
  parameter int unsigned CntW        = 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [mtp_pkg::KindW-1:0]    kind_i,
  input  logic [mtp_pkg::CodeW-1:0]    event_code_i,
  input  logic signed [mtp_pkg::ValueW-1:0] event_value_i,
  input  logic                         clearing_i,
  input  logic                         queue_full_i,
  output logic                         push_o,
  output mtp_pkg::cmd_t                push_cmd_o,
  output logic [CntW-1:0]              push_arg_o
);

  import mtp_pkg::*;

  localparam int unsigned SlotW = (MaxContacts > 1) ? $clog2(MaxContacts) : 1;

  logic [CntW-1:0]        open_q, open_d;
  logic                   abs_seen_q, abs_seen_d;
  logic [MaxContacts-1:0] tm_pos_q, tm_pos_d;

  logic             accept;
  logic             is_abs, is_syn;
  logic             slot_open;
  logic             known;
  field_e           field;
  logic [SlotW-1:0] slot;

  assign in_stall_o = clearing_i || queue_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_abs     = (kind_i == EV_ABS);
  assign is_syn     = (kind_i == EV_SYN);
  assign slot_open  = (open_q < CntW'(MaxContacts));
  assign slot       = open_q[SlotW-1:0];

  // Map an axis code onto a slot field.
  always_comb begin
    known = 1'b1;
    field = FLD_TOUCH_MAJOR;
    case (event_code_i)
      ABS_TOUCH_MAJOR: field = FLD_TOUCH_MAJOR;
      ABS_TOUCH_MINOR: field = FLD_TOUCH_MINOR;
      ABS_WIDTH_MAJOR: field = FLD_WIDTH_MAJOR;
      ABS_WIDTH_MINOR: field = FLD_WIDTH_MINOR;
      ABS_ORIENTATION: field = FLD_ORIENTATION;
      ABS_POSITION_X:  field = FLD_POSITION_X;
      ABS_POSITION_Y:  field = FLD_POSITION_Y;
      ABS_TRACKING_ID: field = FLD_TRACKING_ID;
      ABS_PRESSURE:    field = FLD_PRESSURE;
      default:         known = 1'b0;
    endcase
  end

  // Commands for the back end: slot writes and frame ends.
  always_comb begin
    push_o = accept && ((is_abs && slot_open && known) ||
                        (is_syn && event_code_i == SYNC_FRAME_END));
    push_cmd_o.op    = is_abs ? OP_WRITE : OP_FLUSH;
    push_cmd_o.field = field;
    push_cmd_o.value = event_value_i;
    push_arg_o       = open_q;
  end

  // Frame state: open slot, axis-seen flag and a positive-touch-major mirror.
  always_comb begin
    open_d     = open_q;
    abs_seen_d = abs_seen_q;
    tm_pos_d   = tm_pos_q;
    if (accept && is_abs && slot_open) begin
      abs_seen_d = 1'b1;
      if (known && field == FLD_TOUCH_MAJOR) begin
        tm_pos_d[slot] = (event_value_i != '0) && !event_value_i[ValueW-1];
      end
    end
    if (accept && is_syn && event_code_i == SYNC_CONTACT_END) begin
      if (slot_open && abs_seen_q && tm_pos_q[slot]) begin
        open_d = CntW'(open_q + 1'b1);
      end
    end
    if (accept && is_syn && event_code_i == SYNC_FRAME_END) begin
      open_d     = '0;
      abs_seen_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q     <= '0;
      abs_seen_q <= 1'b0;
      tm_pos_q   <= '0;
    end else begin
      open_q     <= open_d;
      abs_seen_q <= abs_seen_d;
      tm_pos_q   <= tm_pos_d;
    end
  end

endmodule

// ===== design/mtp_back.sv =====
module mtp_back #(
  parameter int unsigned MaxContacts = 16,
  parameter int unsigned CntW        = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_empty_i,
  input  mtp_pkg::cmd_t              cmd_i,
  input  logic [CntW-1:0]            arg_i,
  output logic                       pop_o,
  output logic                       clearing_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       contact_valid_o,
  output logic                       last_o,
  output logic [mtp_pkg::CountW-1:0] contact_count_o,
  output mtp_pkg::row_t              row_o
);

  import mtp_pkg::*;

  localparam int unsigned SlotW = (MaxContacts > 1) ? $clog2(MaxContacts) : 1;

  bk_state_e state_q, state_d;

  row_t             mem_q [MaxContacts];
  row_t             rd_q;
  logic [SlotW-1:0] clr_q, clr_d;
  logic [CntW-1:0]  k_q, k_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic             out_valid_q;
  logic             contact_valid_q;
  logic             last_q;
  logic [CountW-1:0] count_q;
  row_t             row_q;

  logic             out_free;
  logic             is_last;
  logic             clr_done;
  logic             clr_we, wr_we, rd_en;
  logic [SlotW-1:0] rd_addr;
  logic             load, load_empty;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_last    = (CntW'(k_q + 1'b1) == cnt_q);
  assign clr_done   = (clr_q == SlotW'(MaxContacts - 1));
  assign clearing_o = (state_q == BK_CLEAR);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_CLEAR: begin
        if (clr_done) state_d = BK_IDLE;
      end
      BK_IDLE: begin
        if (!cmd_empty_i && cmd_i.op == OP_FLUSH && arg_i != '0) state_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free && is_last) state_d = BK_IDLE;
      end
      default: state_d = BK_CLEAR;
    endcase
  end

  // Sequencer outputs: queue pop, memory access and output load.
  always_comb begin
    pop_o      = 1'b0;
    clr_we     = 1'b0;
    wr_we      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    load       = 1'b0;
    load_empty = 1'b0;
    case (state_q)
      BK_CLEAR: begin
        clr_we = 1'b1;
      end
      BK_IDLE: begin
        if (!cmd_empty_i) begin
          if (cmd_i.op == OP_WRITE) begin
            pop_o = 1'b1;
            wr_we = 1'b1;
          end else if (arg_i == '0) begin
            if (out_free) begin
              pop_o      = 1'b1;
              load       = 1'b1;
              load_empty = 1'b1;
            end
          end else begin
            pop_o = 1'b1;
            rd_en = 1'b1;
          end
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          load = 1'b1;
          if (!is_last) begin
            rd_en   = 1'b1;
            rd_addr = SlotW'(k_q + 1'b1);
          end
        end
      end
      default: ;
    endcase
  end

  // Run counters and clearing index.
  always_comb begin
    clr_d = clr_q;
    k_d   = k_q;
    cnt_d = cnt_q;
    if (clr_we && !clr_done) clr_d = SlotW'(clr_q + 1'b1);
    if (state_q == BK_IDLE && pop_o && cmd_i.op == OP_FLUSH) begin
      k_d   = '0;
      cnt_d = arg_i;
    end
    if (state_q == BK_EMIT && load && !is_last) k_d = CntW'(k_q + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_q       <= '0;
      k_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Slot memory: one write port with field select, one registered read port.
  always_ff @(posedge clk_i) begin
    if (clr_we) begin
      mem_q[clr_q] <= '0;
    end else if (wr_we) begin
      mem_q[arg_i[SlotW-1:0]][cmd_i.field] <= cmd_i.value;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Output beat register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (load_empty) begin
        contact_valid_q <= 1'b0;
        last_q          <= 1'b1;
        count_q         <= '0;
        row_q           <= '0;
      end else begin
        contact_valid_q <= 1'b1;
        last_q          <= is_last;
        count_q         <= CountW'(cnt_q);
        row_q           <= rd_q;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign contact_valid_o = contact_valid_q;
  assign last_o          = last_q;
  assign contact_count_o = count_q;
  assign row_o           = row_q;

endmodule

// ===== design/multitouch_event_frame_parser.sv =====
// Multitouch protocol-A frame parser. Events are taken at one per cycle
// while in_stall_o is low; decoded axis events and frame-end reports go
// into a small command queue. A frame-end report then plays out the
// frame's contacts as a run of beats, one contact per cycle while
// out_stall_i is low, limited by the single read port of the slot memory,
// or one empty beat when no contact was committed. While a run plays out,
// input keeps flowing until the two-entry command queue fills. After reset
// the slot memory is cleared slot by slot, with in_stall_o held high.
module multitouch_event_frame_parser #(
  parameter int unsigned MAX_CONTACTS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mtp_pkg::KindW-1:0]         kind_i,
  input  logic [mtp_pkg::CodeW-1:0]         event_code_i,
  input  logic signed [mtp_pkg::ValueW-1:0] event_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              contact_valid_o,
  output logic                              last_o,
  output logic [mtp_pkg::CountW-1:0]        contact_count_o,
  output logic signed [mtp_pkg::ValueW-1:0] position_x_o,
  output logic signed [mtp_pkg::ValueW-1:0] position_y_o,
  output logic signed [mtp_pkg::ValueW-1:0] touch_major_o,
  output logic signed [mtp_pkg::ValueW-1:0] touch_minor_o,
  output logic signed [mtp_pkg::ValueW-1:0] width_major_o,
  output logic signed [mtp_pkg::ValueW-1:0] width_minor_o,
  output logic signed [mtp_pkg::ValueW-1:0] orientation_o,
  output logic signed [mtp_pkg::ValueW-1:0] pressure_o,
  output logic signed [mtp_pkg::ValueW-1:0] tracking_id_o
);

  import mtp_pkg::*;

  localparam int unsigned CntW   = $clog2(MAX_CONTACTS + 1);
  localparam int unsigned QWidth = $bits(cmd_t) + CntW;

  logic              clearing;
  logic              queue_full, queue_empty;
  logic              push, pop;
  cmd_t              push_cmd, pop_cmd;
  logic [CntW-1:0]   push_arg, pop_arg;
  logic [QWidth-1:0] pop_data;
  row_t              row;

  // Event classification and frame bookkeeping.
  mtp_front #(
    .MaxContacts (MAX_CONTACTS),
    .CntW        (CntW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .event_code_i  (event_code_i),
    .event_value_i (event_value_i),
    .clearing_i    (clearing),
    .queue_full_i  (queue_full),
    .push_o        (push),
    .push_cmd_o    (push_cmd),
    .push_arg_o    (push_arg)
  );

  // Command queue between front and back.
  mtp_cmd_fifo #(
    .Width (QWidth),
    .Depth (2)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_cmd, push_arg}),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (queue_empty),
    .full_o      (queue_full)
  );

  assign pop_cmd = pop_data[QWidth-1:CntW];
  assign pop_arg = pop_data[CntW-1:0];

  // Slot store and result sequencing.
  mtp_back #(
    .MaxContacts (MAX_CONTACTS),
    .CntW        (CntW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_empty_i     (queue_empty),
    .cmd_i           (pop_cmd),
    .arg_i           (pop_arg),
    .pop_o           (pop),
    .clearing_o      (clearing),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .contact_valid_o (contact_valid_o),
    .last_o          (last_o),
    .contact_count_o (contact_count_o),
    .row_o           (row)
  );

  assign position_x_o  = row[FLD_POSITION_X];
  assign position_y_o  = row[FLD_POSITION_Y];
  assign touch_major_o = row[FLD_TOUCH_MAJOR];
  assign touch_minor_o = row[FLD_TOUCH_MINOR];
  assign width_major_o = row[FLD_WIDTH_MAJOR];
  assign width_minor_o = row[FLD_WIDTH_MINOR];
  assign orientation_o = row[FLD_ORIENTATION];
  assign pressure_o    = row[FLD_PRESSURE];
  assign tracking_id_o = row[FLD_TRACKING_ID];

endmodule

// ===== tb/multitouch_event_frame_parser_test.sv =====
`timescale 1ns / 100ps

module multitouch_event_frame_parser_test;
  import mtp_pkg::*;

  localparam int unsigned MaxContacts   = 16;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned SettleCycles  = 40;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned PhaseEvents   = 20;

  // Values outside the decoded sets, used to probe the ignore paths.
  localparam logic [KindW-1:0] KindOther       = 5'd31;
  localparam logic [KindW-1:0] KindLowOther    = 5'd1;
  localparam logic [CodeW-1:0] SynOtherCode    = 10'h001;
  localparam logic [CodeW-1:0] CodeTop         = 10'h3ff;
  localparam logic [CodeW-1:0] AbsUnknownCode  = 10'h037;

  // One result beat as the block presents it.
  typedef struct packed {
    logic              contact_valid;
    logic              last;
    logic [CountW-1:0] contact_count;
    row_t              fields;
  } contact_beat_t;

  // Tracks slot contents and frame state, and holds the contact beats still to come.
  class contact_scoreboard;
    row_t          slot_rows [MaxContacts] = '{default: '0};
    int unsigned   open_count;
    bit            abs_seen;
    contact_beat_t awaited_contacts [$];
    int unsigned   mismatches;
    int unsigned   beats_checked;
    int unsigned   frames_ended;

    // Apply one accepted event beat and queue the beats it causes.
    function void note_event(logic [KindW-1:0] kind, logic [CodeW-1:0] code,
                             logic [ValueW-1:0] value);
      field_e            fld;
      bit                known;
      logic [ValueW-1:0] major;
      contact_beat_t     beat;
      known = 1'b1;
      fld   = FLD_POSITION_X;
      if (kind == EV_ABS) begin
        // Axis values land in the open slot unless the store is full.
        if (open_count < MaxContacts) begin
          case (code)
            ABS_TOUCH_MAJOR: fld = FLD_TOUCH_MAJOR;
            ABS_TOUCH_MINOR: fld = FLD_TOUCH_MINOR;
            ABS_WIDTH_MAJOR: fld = FLD_WIDTH_MAJOR;
            ABS_WIDTH_MINOR: fld = FLD_WIDTH_MINOR;
            ABS_ORIENTATION: fld = FLD_ORIENTATION;
            ABS_POSITION_X:  fld = FLD_POSITION_X;
            ABS_POSITION_Y:  fld = FLD_POSITION_Y;
            ABS_TRACKING_ID: fld = FLD_TRACKING_ID;
            ABS_PRESSURE:    fld = FLD_PRESSURE;
            default:         known = 1'b0;
          endcase
          if (known) slot_rows[open_count][fld] = value;
          abs_seen = 1'b1;
        end
      end else if (kind == EV_SYN && code == SYNC_CONTACT_END) begin
        // A contact report closes the slot only with a positive touch major.
        if (open_count < MaxContacts && abs_seen) begin
          major = slot_rows[open_count][FLD_TOUCH_MAJOR];
          if ($signed(major) > 0) open_count++;
        end
      end else if (kind == EV_SYN && code == SYNC_FRAME_END) begin
        // End of frame: one beat per committed contact, or one empty beat.
        frames_ended++;
        if (open_count == 0) begin
          beat      = '0;
          beat.last = 1'b1;
          awaited_contacts.push_back(beat);
        end else begin
          for (int unsigned k = 0; k < open_count; k++) begin
            beat.contact_valid = 1'b1;
            beat.last          = (k + 1 == open_count);
            beat.contact_count = CountW'(open_count);
            beat.fields        = slot_rows[k];
            awaited_contacts.push_back(beat);
          end
        end
        open_count = 0;
        abs_seen   = 1'b0;
      end
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Compare one accepted result beat with the oldest awaited one.
    task check_beat(contact_beat_t got);
      contact_beat_t want;
      field_e        fld;
      if (awaited_contacts.size() == 0) begin
        report_mismatch("result beat arrived with nothing awaited");
        return;
      end
      want = awaited_contacts.pop_front();
      beats_checked++;
      if (got.contact_valid !== want.contact_valid)
        report_mismatch($sformatf("beat %0d contact_valid got %b want %b",
                                  beats_checked, got.contact_valid, want.contact_valid));
      if (got.last !== want.last)
        report_mismatch($sformatf("beat %0d last got %b want %b",
                                  beats_checked, got.last, want.last));
      if (got.contact_count !== want.contact_count)
        report_mismatch($sformatf("beat %0d contact_count got %0d want %0d",
                                  beats_checked, got.contact_count, want.contact_count));
      for (int f = 0; f < NumFields; f++) begin
        fld = field_e'(f);
        if (got.fields[fld] !== want.fields[fld])
          report_mismatch($sformatf("beat %0d %s got %h want %h", beats_checked,
                                    fld.name(), got.fields[fld], want.fields[fld]));
      end
    endtask
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [KindW-1:0]           kind_i;
  logic [CodeW-1:0]           event_code_i;
  logic signed [ValueW-1:0]   event_value_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic                       contact_valid_o;
  logic                       last_o;
  logic [CountW-1:0]          contact_count_o;
  logic signed [ValueW-1:0]   position_x_o;
  logic signed [ValueW-1:0]   position_y_o;
  logic signed [ValueW-1:0]   touch_major_o;
  logic signed [ValueW-1:0]   touch_minor_o;
  logic signed [ValueW-1:0]   width_major_o;
  logic signed [ValueW-1:0]   width_minor_o;
  logic signed [ValueW-1:0]   orientation_o;
  logic signed [ValueW-1:0]   pressure_o;
  logic signed [ValueW-1:0]   tracking_id_o;

  contact_scoreboard sb = new();

  int unsigned sender_idle_pct  = 0;
  int unsigned recv_stall_pct   = 0;
  int unsigned hold_off_request = 0;
  int unsigned events_sent      = 0;

  logic [CodeW-1:0] axis_codes [9] = '{ABS_TOUCH_MAJOR, ABS_TOUCH_MINOR, ABS_WIDTH_MAJOR,
                                       ABS_WIDTH_MINOR, ABS_ORIENTATION, ABS_POSITION_X,
                                       ABS_POSITION_Y, ABS_TRACKING_ID, ABS_PRESSURE};

  multitouch_event_frame_parser #(
    .MAX_CONTACTS(MaxContacts)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .event_code_i    (event_code_i),
    .event_value_i   (event_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .contact_valid_o (contact_valid_o),
    .last_o          (last_o),
    .contact_count_o (contact_count_o),
    .position_x_o    (position_x_o),
    .position_y_o    (position_y_o),
    .touch_major_o   (touch_major_o),
    .touch_minor_o   (touch_minor_o),
    .width_major_o   (width_major_o),
    .width_minor_o   (width_minor_o),
    .orientation_o   (orientation_o),
    .pressure_o      (pressure_o),
    .tracking_id_o   (tracking_id_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Axis values skewed toward the extremes.
  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(5))
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      2:       return 32'(int'($urandom_range(255)) - 128);
      default: return $urandom();
    endcase
  endfunction

  // Offer one event beat, after a random gap, and hold it until accepted.
  task automatic send_event(logic [KindW-1:0] kind, logic [CodeW-1:0] code,
                            logic [ValueW-1:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    event_code_i  <= code;
    event_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_event(kind, code, value);
    if (kind == EV_ABS || kind == EV_SYN) events_sent++;
  endtask

  task automatic send_noise();
    send_event(KindW'($urandom_range(31)), CodeW'($urandom_range(1023)), $urandom());
  endtask

  // A frame of contacts; a tidy frame commits every contact it can.
  task automatic send_frame(int unsigned contacts, bit tidy);
    for (int unsigned c = 0; c < contacts; c++) begin
      if (tidy || $urandom_range(9) != 0)
        send_event(EV_ABS, ABS_TOUCH_MAJOR, $urandom_range(32'h7fffffff, 1));
      else
        send_event(EV_ABS, ABS_TOUCH_MAJOR, pick_value());
      repeat ($urandom_range(tidy ? 1 : 3)) begin
        if (!tidy && $urandom_range(9) == 0)
          send_event(EV_ABS, CodeW'($urandom_range(1023)), pick_value());
        else
          send_event(EV_ABS, axis_codes[$urandom_range(8)], pick_value());
      end
      if (!tidy && $urandom_range(14) == 0) send_noise();
      if (tidy || $urandom_range(9) != 0) send_event(EV_SYN, SYNC_CONTACT_END, $urandom());
    end
    send_event(EV_SYN, SYNC_FRAME_END, $urandom());
  endtask

  // Stop offering and wait for every awaited beat to come out.
  task automatic drain_frames();
    in_valid_i <= 1'b0;
    while (sb.awaited_contacts.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct);
    int unsigned start;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    start = events_sent;
    while (events_sent - start < PhaseEvents) begin
      if ($urandom_range(9) == 0)
        send_noise();
      else if ($urandom_range(19) == 0)
        send_frame($urandom_range(MaxContacts + 2, MaxContacts), 1'b0);
      else
        send_frame($urandom_range(4), 1'b0);
    end
    drain_frames();
  endtask

  // Result side: check accepted beats, then pick the next stall value.
  initial begin : result_sink
    int unsigned   hold_left;
    contact_beat_t got;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.contact_valid                = contact_valid_o;
        got.last                         = last_o;
        got.contact_count                = contact_count_o;
        got.fields[FLD_POSITION_X]  = position_x_o;
        got.fields[FLD_POSITION_Y]  = position_y_o;
        got.fields[FLD_TOUCH_MAJOR] = touch_major_o;
        got.fields[FLD_TOUCH_MINOR] = touch_minor_o;
        got.fields[FLD_WIDTH_MAJOR] = width_major_o;
        got.fields[FLD_WIDTH_MINOR] = width_minor_o;
        got.fields[FLD_ORIENTATION] = orientation_o;
        got.fields[FLD_PRESSURE]    = pressure_o;
        got.fields[FLD_TRACKING_ID] = tracking_id_o;
        sb.check_beat(got);
      end
      if (hold_off_request != 0) begin
        hold_left        = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles <= CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("multitouch_event_frame_parser verification failed");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    kind_i        = '0;
    event_code_i  = '0;
    event_value_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty frame, every axis code at the extremes, ignored events,
    // rejected contact reports and reuse of old slot contents.
    send_event(EV_SYN, SYNC_FRAME_END, 32'h0);
    send_event(EV_SYN, SYNC_CONTACT_END, 32'hffffffff);
    send_event(EV_ABS, ABS_TOUCH_MAJOR, 32'h7fffffff);
    send_event(EV_ABS, ABS_TOUCH_MINOR, 32'h80000000);
    send_event(EV_ABS, ABS_WIDTH_MAJOR, 32'hffffffff);
    send_event(EV_ABS, ABS_WIDTH_MINOR, 32'h0);
    send_event(EV_ABS, ABS_ORIENTATION, 32'h1);
    send_event(EV_ABS, ABS_POSITION_X, 32'h7fffffff);
    send_event(EV_ABS, ABS_POSITION_Y, 32'h80000000);
    send_event(EV_ABS, ABS_TRACKING_ID, 32'h55555555);
    send_event(EV_ABS, ABS_PRESSURE, 32'haaaaaaaa);
    send_event(EV_ABS, CodeTop, 32'hffffffff);
    send_event(KindOther, CodeTop, 32'hffffffff);
    send_event(KindLowOther, SYNC_FRAME_END, 32'h0);
    send_event(EV_SYN, SynOtherCode, 32'h0);
    send_event(EV_SYN, CodeTop, 32'h0);
    send_event(EV_SYN, SYNC_CONTACT_END, 32'h0);
    send_event(EV_ABS, ABS_TOUCH_MAJOR, 32'h0);
    send_event(EV_SYN, SYNC_CONTACT_END, 32'h0);
    send_event(EV_ABS, ABS_TOUCH_MAJOR, 32'h80000000);
    send_event(EV_SYN, SYNC_CONTACT_END, 32'h0);
    send_event(EV_ABS, ABS_TOUCH_MAJOR, 32'h1);
    send_event(EV_SYN, SYNC_CONTACT_END, 32'h0);
    send_event(EV_SYN, SYNC_FRAME_END, 32'h0);
    send_event(EV_ABS, AbsUnknownCode, 32'h0);
    send_event(EV_SYN, SYNC_CONTACT_END, 32'h0);
    send_event(EV_SYN, SYNC_FRAME_END, 32'h0);
    drain_frames();

    // Long hold-off on the result side while a frame past the store size
    // and a following frame keep coming, so the block backs up into its input.
    hold_off_request = HoldOffCycles;
    send_frame(MaxContacts + 1, 1'b1);
    send_frame(3, 1'b1);
    drain_frames();

    // Random frames under each idling pattern.
    run_phase(0, 0);
    run_phase(85, 0);
    run_phase(0, 85);
    run_phase(25, 25);

    repeat (SettleCycles) @(posedge clk_i);
    if (sb.awaited_contacts.size() != 0)
      sb.report_mismatch($sformatf("%0d result beats never arrived",
                                   sb.awaited_contacts.size()));

    $display("Run covered %0d axis and sync events over %0d frames, %0d result beats checked,",
             events_sent, sb.frames_ended, sb.beats_checked);
    $display("including empty and overfull frames, rejected reports and ignored events.");
    if (sb.mismatches == 0)
      $display("multitouch_event_frame_parser verification clean");
    else
      $display("multitouch_event_frame_parser verification failed");
    $finish;
  end

endmodule
